// ===== hdl/ihr_pkg.sv =====
// ihr_pkg: types, codes and helper functions for the input event to HID report block.
// Used by ihr_event_proc and input_event_to_hid_report.
`default_nettype none

package ihr_pkg;

	localparam int unsigned BTN_W  = 5;
	localparam int unsigned TYPE_W = 3;

	typedef enum logic [TYPE_W-1:0] {
		EV_KEY    = 3'd0,
		EV_MOVE   = 3'd1,
		EV_BUTTON = 3'd2,
		EV_WHEEL  = 3'd3
	} ev_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_NOT_SUPP  = 2'd2,
		ST_INVALID   = 2'd3
	} status_t;

	localparam logic [1:0] RID_NONE  = 2'd0;
	localparam logic [1:0] RID_KBD   = 2'd1;
	localparam logic [1:0] RID_MOUSE = 2'd2;

	localparam logic signed [31:0] MAX_DELTA = 32'sd127;

	typedef struct packed {
		logic [TYPE_W-1:0]  req_type;
		logic signed [31:0] value_a;
		logic signed [31:0] value_b;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic              report_sent;
		logic [1:0]        report_id;
		logic [7:0]        modifiers;
		logic [7:0]        key_usage;
		logic [BTN_W-1:0]  buttons;
		logic signed [7:0] delta_x;
		logic signed [7:0] delta_y;
		logic signed [7:0] wheel_vertical;
		logic signed [7:0] wheel_horizontal;
	} rsp_t;

	typedef struct packed {
		logic             we;
		logic [BTN_W-1:0] value;
	} btn_upd_t;

	function automatic logic [7:0] sat8(input logic signed [31:0] v);
		logic [7:0] r;
		if (v > MAX_DELTA) begin
			r = MAX_DELTA[7:0];
		end else if (v < -MAX_DELTA) begin
			r = 8'h81;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	function automatic logic [BTN_W-1:0] button_bit(input logic signed [31:0] n);
		logic [BTN_W-1:0] m;
		unique case (n)
			32'sd1:  m = 5'h01;
			32'sd2:  m = 5'h04;
			32'sd3:  m = 5'h02;
			32'sd4:  m = 5'h08;
			32'sd5:  m = 5'h10;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ihr_kbd_map.sv =====
// ihr_kbd_map: maps a virtual-key code to a modifier bit and a key usage.
// Uses no package.
`default_nettype none

module ihr_kbd_map (
	input  wire logic signed [31:0] key,
	output logic [7:0]              mod_bit,
	output logic [7:0]              usage
);

	logic       hi_zero;
	logic [7:0] k;

	assign hi_zero = (key[31:8] == 24'd0);
	assign k       = key[7:0];

	always_comb begin
		mod_bit = '0;
		if (hi_zero) begin
			unique case (k)
				8'h10, 8'hA0: mod_bit = 8'h02;
				8'hA1:        mod_bit = 8'h20;
				8'h11, 8'hA2: mod_bit = 8'h01;
				8'hA3:        mod_bit = 8'h10;
				8'h12, 8'hA4: mod_bit = 8'h04;
				8'hA5:        mod_bit = 8'h40;
				8'h5B:        mod_bit = 8'h08;
				8'h5C:        mod_bit = 8'h80;
				default:      mod_bit = '0;
			endcase
		end
	end

	always_comb begin
		usage = '0;
		if (hi_zero) begin
			priority if (k >= 8'h41 && k <= 8'h5A) begin
				usage = k - 8'h3D;
			end else if (k >= 8'h31 && k <= 8'h39) begin
				usage = k - 8'h13;
			end else begin
				unique case (k)
					8'h30:   usage = 8'h27;
					8'h0D:   usage = 8'h28;
					8'h1B:   usage = 8'h29;
					8'h08:   usage = 8'h2A;
					8'h09:   usage = 8'h2B;
					8'h20:   usage = 8'h2C;
					default: usage = '0;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ihr_event_proc.sv =====
// ihr_event_proc: builds the result of one request from the registered request,
// the attach flag and the held buttons. Depends on ihr_pkg and ihr_kbd_map.
`default_nettype none

module ihr_event_proc (
	input  wire ihr_pkg::req_t               req,
	input  wire logic                        attached,
	input  wire logic [ihr_pkg::BTN_W-1:0]   held,
	output ihr_pkg::rsp_t                    rsp,
	output ihr_pkg::btn_upd_t                upd
);

	logic [7:0]                mod_bit;
	logic [7:0]                usage;
	logic                      down;
	logic [ihr_pkg::BTN_W-1:0] m;
	logic [ihr_pkg::BTN_W-1:0] held_new;

	ihr_kbd_map u_kbd_map (
		.key     (req.value_a),
		.mod_bit (mod_bit),
		.usage   (usage)
	);

	assign down     = (req.value_b != 32'sd0);
	assign m        = ihr_pkg::button_bit(req.value_a);
	assign held_new = down ? (held | m) : (held & ~m);

	always_comb begin
		rsp       = '0;
		upd       = '0;
		upd.value = held_new;
		if (!attached) begin
			rsp.status = ihr_pkg::ST_NOT_READY;
		end else begin
			unique case (req.req_type)
				ihr_pkg::EV_KEY: begin
					if (mod_bit == 8'd0 && usage == 8'd0) begin
						rsp.status = ihr_pkg::ST_NOT_SUPP;
					end else begin
						rsp.report_sent = 1'b1;
						rsp.report_id   = ihr_pkg::RID_KBD;
						if (mod_bit != 8'd0) begin
							rsp.modifiers = down ? mod_bit : 8'd0;
						end else if (down) begin
							rsp.key_usage = usage;
						end
					end
				end
				ihr_pkg::EV_MOVE: begin
					rsp.report_sent = 1'b1;
					rsp.report_id   = ihr_pkg::RID_MOUSE;
					rsp.buttons     = held;
					rsp.delta_x     = ihr_pkg::sat8(req.value_a);
					rsp.delta_y     = ihr_pkg::sat8(req.value_b);
				end
				ihr_pkg::EV_WHEEL: begin
					rsp.report_sent      = 1'b1;
					rsp.report_id        = ihr_pkg::RID_MOUSE;
					rsp.buttons          = held;
					rsp.wheel_vertical   = ihr_pkg::sat8(req.value_b);
					rsp.wheel_horizontal = ihr_pkg::sat8(req.value_a);
				end
				ihr_pkg::EV_BUTTON: begin
					if (m == '0) begin
						rsp.status = ihr_pkg::ST_NOT_SUPP;
					end else begin
						upd.we          = 1'b1;
						rsp.report_sent = 1'b1;
						rsp.report_id   = ihr_pkg::RID_MOUSE;
						rsp.buttons     = held_new;
					end
				end
				default: begin
					rsp.status = ihr_pkg::ST_INVALID;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/input_event_to_hid_report.sv =====
// input_event_to_hid_report: top level, request register, result register,
// attach flag and held button state. Depends on ihr_pkg and ihr_event_proc.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   ihr_pkg::req_t
//   rsp      out        rsp_valid/rsp_stall   ihr_pkg::rsp_t
//   cfg      in         cfg_we                cfg_wdata (device_attached)
//
// Result path: request register, decode, result register; one request per cycle
// sustained while rsp_stall is low; the decode between them is combinational.
// Reset clears the attach flag, the held buttons and both valid flags.
// A stalled result holds; the request register keeps taking requests while it has room.
`default_nettype none

module input_event_to_hid_report (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ihr_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ihr_pkg::rsp_t      rsp,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata
);

	logic                      valid_s1;
	ihr_pkg::req_t             req_s1;
	logic                      valid_s2;
	ihr_pkg::rsp_t             rsp_s2;
	logic                      attached_q;
	logic [ihr_pkg::BTN_W-1:0] held_q;
	logic                      adv_s1;
	logic                      adv_s2;
	ihr_pkg::rsp_t             rsp_next;
	ihr_pkg::btn_upd_t         upd;

	assign adv_s2    = !valid_s2 || !rsp_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_stall = !adv_s1;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	ihr_event_proc u_event_proc (
		.req      (req_s1),
		.attached (attached_q),
		.held     (held_q),
		.rsp      (rsp_next),
		.upd      (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attached_q <= 1'b0;
			held_q     <= '0;
		end else if (cfg_we) begin
			attached_q <= cfg_wdata;
			if (!cfg_wdata) begin
				held_q <= '0;
			end
		end else if (adv_s2 && valid_s1 && upd.we) begin
			held_q <= upd.value;
		end
	end

`ifndef SYNTH
	a_idle_report: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.report_sent |-> rsp.report_id == ihr_pkg::RID_NONE)
		else $error("result without report carries a report id");

	a_sent_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.report_sent |-> rsp.status == ihr_pkg::ST_OK)
		else $error("report sent with error status");

	a_detach_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && !cfg_wdata |=> held_q == '0)
		else $error("detach did not clear held buttons");

	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && !attached_q && !cfg_we |=>
		rsp_valid && rsp.status == ihr_pkg::ST_NOT_READY)
		else $error("detached device gave wrong status");
`endif

endmodule

`default_nettype wire

// ===== tb/input_event_to_hid_report_test.sv =====
// input_event_to_hid_report_test: self-checking bench for the input event to HID report block.
// Predicts every report from its own model of the key, button and movement rules.
// Depends on ihr_pkg and input_event_to_hid_report.
`default_nettype none

module input_event_to_hid_report_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] EV_FIRST_UNKNOWN = 3'd4;
	localparam logic [2:0] EV_UNKNOWN_ALT   = 3'd5;
	localparam logic [2:0] EV_LAST_CODE     = 3'd7;

	localparam int DELTA_LIMIT  = 127;
	localparam int MAX_WAIT     = 12;
	localparam int IDLE_LIMIT   = 1000;
	localparam int REPORT_LIMIT = 10;

	localparam int VK_BACK     = 'h08;
	localparam int VK_TAB      = 'h09;
	localparam int VK_RETURN   = 'h0D;
	localparam int VK_SHIFT    = 'h10;
	localparam int VK_CONTROL  = 'h11;
	localparam int VK_MENU     = 'h12;
	localparam int VK_ESCAPE   = 'h1B;
	localparam int VK_SPACE    = 'h20;
	localparam int VK_0        = 'h30;
	localparam int VK_1        = 'h31;
	localparam int VK_9        = 'h39;
	localparam int VK_A        = 'h41;
	localparam int VK_Z        = 'h5A;
	localparam int VK_LWIN     = 'h5B;
	localparam int VK_RWIN     = 'h5C;
	localparam int VK_LSHIFT   = 'hA0;
	localparam int VK_RSHIFT   = 'hA1;
	localparam int VK_LCONTROL = 'hA2;
	localparam int VK_RCONTROL = 'hA3;
	localparam int VK_LMENU    = 'hA4;
	localparam int VK_RMENU    = 'hA5;

	localparam logic [7:0] MOD_LCTRL  = 8'h01;
	localparam logic [7:0] MOD_LSHIFT = 8'h02;
	localparam logic [7:0] MOD_LALT   = 8'h04;
	localparam logic [7:0] MOD_LGUI   = 8'h08;
	localparam logic [7:0] MOD_RCTRL  = 8'h10;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;
	localparam logic [7:0] MOD_RALT   = 8'h40;
	localparam logic [7:0] MOD_RGUI   = 8'h80;

	localparam logic [7:0] USAGE_A     = 8'h04;
	localparam logic [7:0] USAGE_1     = 8'h1E;
	localparam logic [7:0] USAGE_0     = 8'h27;
	localparam logic [7:0] USAGE_ENTER = 8'h28;
	localparam logic [7:0] USAGE_ESC   = 8'h29;
	localparam logic [7:0] USAGE_BKSP  = 8'h2A;
	localparam logic [7:0] USAGE_TAB   = 8'h2B;
	localparam logic [7:0] USAGE_SPACE = 8'h2C;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	ihr_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	ihr_pkg::rsp_t rsp;
	logic          cfg_we;
	logic          cfg_wdata;

	ihr_pkg::rsp_t             pending_reports[$];
	logic                      model_attached;
	logic [ihr_pkg::BTN_W-1:0] model_buttons;
	bit                        bursty;
	int                        failures;
	int                        idle_cycles;

	input_event_to_hid_report i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] modifier_of(input int k);
		case (k)
			VK_SHIFT, VK_LSHIFT:     return MOD_LSHIFT;
			VK_RSHIFT:               return MOD_RSHIFT;
			VK_CONTROL, VK_LCONTROL: return MOD_LCTRL;
			VK_RCONTROL:             return MOD_RCTRL;
			VK_MENU, VK_LMENU:       return MOD_LALT;
			VK_RMENU:                return MOD_RALT;
			VK_LWIN:                 return MOD_LGUI;
			VK_RWIN:                 return MOD_RGUI;
			default:                 return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] usage_of(input int k);
		if (k >= VK_A && k <= VK_Z) begin
			return USAGE_A + 8'(k - VK_A);
		end
		if (k >= VK_1 && k <= VK_9) begin
			return USAGE_1 + 8'(k - VK_1);
		end
		case (k)
			VK_0:      return USAGE_0;
			VK_RETURN: return USAGE_ENTER;
			VK_ESCAPE: return USAGE_ESC;
			VK_BACK:   return USAGE_BKSP;
			VK_TAB:    return USAGE_TAB;
			VK_SPACE:  return USAGE_SPACE;
			default:   return 8'h00;
		endcase
	endfunction

	function automatic logic [ihr_pkg::BTN_W-1:0] mouse_bit_of(input int n);
		case (n)
			1:       return 5'h01;
			2:       return 5'h04;
			3:       return 5'h02;
			4:       return 5'h08;
			5:       return 5'h10;
			default: return 5'h00;
		endcase
	endfunction

	function automatic logic [7:0] clamp_delta(input int v);
		if (v > DELTA_LIMIT) begin
			return 8'(DELTA_LIMIT);
		end
		if (v < -DELTA_LIMIT) begin
			return 8'(-DELTA_LIMIT);
		end
		return v[7:0];
	endfunction

	// Advances the held button state as a side effect.
	function automatic ihr_pkg::rsp_t hid_report_of(input ihr_pkg::req_t r);
		ihr_pkg::rsp_t             o;
		int                        a;
		int                        b;
		logic [7:0]                mod;
		logic [7:0]                usage;
		logic [ihr_pkg::BTN_W-1:0] m;
		o = '0;
		a = r.value_a;
		b = r.value_b;
		if (!model_attached) begin
			o.status = ihr_pkg::ST_NOT_READY;
		end else begin
			case (r.req_type)
				ihr_pkg::EV_KEY: begin
					mod = modifier_of(a);
					usage = usage_of(a);
					if (mod == 0 && usage == 0) begin
						o.status = ihr_pkg::ST_NOT_SUPP;
					end else begin
						o.report_sent = 1'b1;
						o.report_id = ihr_pkg::RID_KBD;
						if (mod != 0) begin
							o.modifiers = (b != 0) ? mod : 8'h00;
						end else if (b != 0) begin
							o.key_usage = usage;
						end
					end
				end
				ihr_pkg::EV_MOVE, ihr_pkg::EV_WHEEL: begin
					o.report_sent = 1'b1;
					o.report_id = ihr_pkg::RID_MOUSE;
					o.buttons = model_buttons;
					if (r.req_type == ihr_pkg::EV_MOVE) begin
						o.delta_x = clamp_delta(a);
						o.delta_y = clamp_delta(b);
					end else begin
						o.wheel_vertical = clamp_delta(b);
						o.wheel_horizontal = clamp_delta(a);
					end
				end
				ihr_pkg::EV_BUTTON: begin
					m = mouse_bit_of(a);
					if (m == 0) begin
						o.status = ihr_pkg::ST_NOT_SUPP;
					end else begin
						model_buttons = (b != 0) ? (model_buttons | m) : (model_buttons & ~m);
						o.report_sent = 1'b1;
						o.report_id = ihr_pkg::RID_MOUSE;
						o.buttons = model_buttons;
					end
				end
				default: begin
					o.status = ihr_pkg::ST_INVALID;
				end
			endcase
		end
		return o;
	endfunction

	function automatic string fmt_report(input ihr_pkg::rsp_t p);
		return $sformatf("st=%0d sent=%0b id=%0d mod=%h key=%h btn=%h dx=%h dy=%h wv=%h wh=%h",
			p.status, p.report_sent, p.report_id, p.modifiers, p.key_usage, p.buttons,
			p.delta_x, p.delta_y, p.wheel_vertical, p.wheel_horizontal);
	endfunction

	// Check results first, then predict the request taken at the same edge.
	always @(posedge clk) begin
		ihr_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_reports.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("unexpected report: %s", fmt_report(rsp));
				end
			end else begin
				want = pending_reports.pop_front();
				if (rsp !== want) begin
					failures++;
					if (failures <= REPORT_LIMIT) begin
						$display("report mismatch at %0t", $realtime);
						$display("  expected %s", fmt_report(want));
						$display("  actual   %s", fmt_report(rsp));
					end
				end
			end
		end
		if (arst_n && req_valid && !req_stall) begin
			pending_reports.push_back(hid_report_of(req));
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
			$display("** input_event_to_hid_report: FAILED **");
			$finish;
		end
	end

	initial begin
		int w;
		rsp_stall = 1'b0;
		forever begin
			w = bursty ? $urandom_range(0, MAX_WAIT) : 0;
			rsp_stall = (w != 0);
			repeat (w) @(negedge clk);
			rsp_stall = 1'b0;
			do @(posedge clk); while (!rsp_valid);
			@(negedge clk);
		end
	end

	function automatic ihr_pkg::req_t mk_req(input logic [2:0] kind, input int a, input int b);
		ihr_pkg::req_t r;
		r.req_type = kind;
		r.value_a = a;
		r.value_b = b;
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the accept.
	task automatic send_req(input ihr_pkg::req_t r);
		int gap;
		gap = bursty ? $urandom_range(0, MAX_WAIT) : 0;
		repeat (gap) @(negedge clk);
		req = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		req_valid = 1'b0;
	endtask

	task automatic drain;
		while (pending_reports.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_attached(input logic v);
		drain();
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		model_attached = v;
		if (!v) begin
			model_buttons = '0;
		end
	endtask

	function automatic int pressed_flag();
		int r;
		r = $urandom_range(0, 5);
		if (r < 2) begin
			return 0;
		end
		if (r == 2) begin
			return 1;
		end
		if (r == 3) begin
			return 32'h8000_0000;
		end
		return $urandom;
	endfunction

	function automatic int some_delta();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom;
		end
		return $urandom_range(0, 400) - 200;
	endfunction

	function automatic int pick_key_code();
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 12))
					0:       return VK_SHIFT;
					1:       return VK_CONTROL;
					2:       return VK_MENU;
					3:       return VK_LWIN;
					4:       return VK_RWIN;
					5:       return VK_LSHIFT;
					6:       return VK_RSHIFT;
					7:       return VK_LCONTROL;
					8:       return VK_RCONTROL;
					9:       return VK_LMENU;
					10:      return VK_RMENU;
					11:      return VK_LWIN;
					default: return VK_RWIN;
				endcase
			end
			1: return VK_A + $urandom_range(0, 25);
			2: return VK_0 + $urandom_range(0, 9);
			3: begin
				case ($urandom_range(0, 4))
					0:       return VK_RETURN;
					1:       return VK_ESCAPE;
					2:       return VK_BACK;
					3:       return VK_TAB;
					default: return VK_SPACE;
				endcase
			end
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic ihr_pkg::req_t random_event();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			return mk_req(3'($urandom_range(0, EV_LAST_CODE)), $urandom, $urandom);
		end
		if (sel < 35) begin
			return mk_req(ihr_pkg::EV_KEY, pick_key_code(), pressed_flag());
		end
		if (sel < 55) begin
			return mk_req(ihr_pkg::EV_MOVE, some_delta(), some_delta());
		end
		if (sel < 75) begin
			return mk_req(ihr_pkg::EV_BUTTON,
				($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(0, 9),
				pressed_flag());
		end
		if (sel < 92) begin
			return mk_req(ihr_pkg::EV_WHEEL, some_delta(), some_delta());
		end
		return mk_req(3'($urandom_range(EV_FIRST_UNKNOWN, EV_LAST_CODE)), $urandom, $urandom);
	endfunction

	task automatic send_random(input int count);
		repeat (count) send_req(random_event());
	endtask

	task automatic test_detached;
		send_req(mk_req(ihr_pkg::EV_KEY, VK_A, 1));
		send_req(mk_req(EV_UNKNOWN_ALT, 0, 0));
		set_attached(1'b0);
		send_req(mk_req(ihr_pkg::EV_BUTTON, 1, 1));
		set_attached(1'b1);
	endtask

	task automatic test_keyboard;
		send_req(mk_req(ihr_pkg::EV_KEY, VK_RMENU, 1));
		send_req(mk_req(ihr_pkg::EV_KEY, VK_RWIN, 0));
		send_req(mk_req(ihr_pkg::EV_KEY, VK_A, -1));
		send_req(mk_req(ihr_pkg::EV_KEY, VK_0, 32'h8000_0000));
		send_req(mk_req(ihr_pkg::EV_KEY, VK_9, 7));
		send_req(mk_req(ihr_pkg::EV_KEY, VK_SPACE, 0));
		send_req(mk_req(ihr_pkg::EV_KEY, 'h7F, 1));
		send_req(mk_req(ihr_pkg::EV_KEY, 32'h8000_0041, 1));
	endtask

	task automatic test_mouse;
		send_req(mk_req(ihr_pkg::EV_MOVE, 32'h7FFF_FFFF, 32'h8000_0000));
		send_req(mk_req(ihr_pkg::EV_MOVE, 128, -128));
		send_req(mk_req(ihr_pkg::EV_MOVE, -127, 127));
		send_req(mk_req(ihr_pkg::EV_WHEEL, -300, 1));
		send_req(mk_req(ihr_pkg::EV_BUTTON, 1, 1));
		send_req(mk_req(ihr_pkg::EV_BUTTON, 5, -1));
		send_req(mk_req(ihr_pkg::EV_BUTTON, 0, 1));
		send_req(mk_req(ihr_pkg::EV_BUTTON, 6, 1));
		send_req(mk_req(ihr_pkg::EV_MOVE, 0, 0));
		send_req(mk_req(ihr_pkg::EV_BUTTON, 1, 0));
		send_req(mk_req(EV_FIRST_UNKNOWN, 0, 0));
		send_req(mk_req(EV_LAST_CODE, -1, -1));
	endtask

	task automatic test_detach_clears_buttons;
		set_attached(1'b0);
		set_attached(1'b1);
		send_req(mk_req(ihr_pkg::EV_MOVE, 1, -1));
	endtask

	task automatic test_random;
		set_attached(1'b1);
		bursty = 1'b1;
		send_random(450);
		bursty = 1'b0;
		send_random(250);
		set_attached(1'b0);
		bursty = 1'b1;
		send_random(80);
		set_attached(1'b1);
		send_random(500);
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		bursty = 1'b1;
		failures = 0;
		idle_cycles = 0;
		model_attached = 1'b0;
		model_buttons = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_detached();
		test_keyboard();
		test_mouse();
		test_detach_clears_buttons();
		test_random();

		drain();
		repeat (4) @(negedge clk);
		if (failures == 0) begin
			$display("** input_event_to_hid_report: PASSED **");
		end else begin
			$display("** input_event_to_hid_report: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
